### design/assert_macros.svh
// Assertion macros for the RTL of the timer event queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/ostq_pkg.sv
// Package with beat types, codes and defaults of the timer event queue.
`timescale 1ns / 1ps
`default_nettype none
package ostq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned TagBitsDefault    = 8;

  localparam logic OP_SCHED = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_FULL   = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [23:0] delay_us;
    logic [7:0]  tag;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] fired_tag;
    logic       last;
  } out_beat_t;

endpackage
`default_nettype wire

### design/ostq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ostq_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### design/ostq_sub.sv
// Shared 32-bit subtractor used for time-relative compares and reloads.
`timescale 1ns / 1ps
`default_nettype none
module ostq_sub (
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] diff_o
);

  // Modulo 2^32 difference keeps all time compares wrap-safe.
  assign diff_o = a_i - b_i;

endmodule
`default_nettype wire

### design/one_shot_timer_event_queue_core.sv
// Top level of the one-shot timer event queue: sequencer, store and countdown.
//
// Usage: input beats arrive on in_valid_i/in_ready_o carrying an opcode, a
// delay and a tag. A schedule beat files a timer and always yields exactly
// one result beat (accepted or full). A tick beat advances time by one
// microsecond and yields no result unless the countdown expires, in which
// case every timer due at that instant is released oldest first, one result
// beat each, with last set on the final one.
// Steps: an unexpired tick and a schedule on an empty or full queue finish
// in the idle state. A schedule on a non-empty queue walks the sorted store
// from the tail, a read state and a compare-and-write state per entry moved,
// over at most n live entries; the single-port store read sets that. An
// expiry runs the tick, a read and a data state per popped entry, then a
// reload from the next head or a final state when empty, plus stalls.
// The store is a circular buffer kept sorted by fire time; a head pointer
// makes a pop a single pointer step.
// Reset empties the queue and stops the countdown; no clearing pass is run.
// When the receiver stalls, the result waits in the output register and the
// sequencer holds; no new beat is taken until the result is delivered.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module one_shot_timer_event_queue_core #(
  parameter int unsigned QUEUE_DEPTH = ostq_pkg::QueueDepthDefault,
  parameter int unsigned TAG_BITS    = ostq_pkg::TagBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ostq_pkg::in_beat_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ostq_pkg::out_beat_t    out_data_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW = TAG_BITS;
  localparam int unsigned RW = 32 + TW;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_EXP_RD  = 3'd3;
  localparam logic [2:0] S_EXP_DAT = 3'd4;
  localparam logic [2:0] S_EXP_FIN = 3'd5;

  // Physical slot of logical entry off, counted from the head pointer.
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [2:0]          state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]       hd_q, hd_d;
  logic [23:0]         cd_q, cd_d;
  logic [31:0]         head_time_q, head_time_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [31:0]         now_q, now_d;
  logic [23:0]         dly_q, dly_d;
  logic [TW-1:0]       ntag_q, ntag_d;
  logic [TW-1:0]       pend_tag_q, pend_tag_d;
  logic                pend_v_q, pend_v_d;
  logic                out_v_q, out_v_d;
  ostq_pkg::out_beat_t out_q, out_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic [31:0]   sub_a, sub_b, sub_diff;
  logic [31:0]   rd_ft;
  logic [TW-1:0] rd_tag;
  logic [31:0]   fire;
  logic [23:0]   in_dly;
  logic [TW-1:0] in_tag;
  logic          out_free;

  assign rd_ft    = ram_rdata[RW-1:TW];
  assign rd_tag   = ram_rdata[TW-1:0];
  assign fire     = now_q + {8'd0, dly_q};
  assign in_dly   = (in_data_i.delay_us == 24'd0) ? 24'd1 : in_data_i.delay_us;
  assign in_tag   = TW'(in_data_i.tag);
  assign out_free = !out_v_q || out_ready_i;

  assign in_ready_o  = (state_q == S_IDLE) && !out_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  ostq_ram #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ostq_sub u_sub (
    .a_i    (sub_a),
    .b_i    (sub_b),
    .diff_o (sub_diff)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    hd_d        = hd_q;
    cd_d        = cd_q;
    head_time_d = head_time_q;
    idx_d       = idx_q;
    now_d       = now_q;
    dly_d       = dly_q;
    ntag_d      = ntag_q;
    pend_tag_d  = pend_tag_q;
    pend_v_d    = pend_v_q;
    out_v_d     = out_v_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    sub_a       = rd_ft;
    sub_b       = now_q;

    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        // Current time is the head fire time minus the remaining count.
        sub_a = head_time_q;
        sub_b = {8'd0, cd_q};
        if (in_valid_i && in_ready_o) begin
          if (in_data_i.opcode == ostq_pkg::OP_SCHED) begin
            out_v_d         = 1'b1;
            out_d.fired_tag = 8'(in_tag);
            out_d.last      = 1'b1;
            if (cnt_q == CW'(QUEUE_DEPTH)) begin
              out_d.kind = ostq_pkg::KIND_FULL;
            end else if (cnt_q == '0) begin
              out_d.kind  = ostq_pkg::KIND_ACCEPT;
              ram_we      = 1'b1;
              ram_waddr   = hd_q;
              ram_wdata   = {8'd0, in_dly, in_tag};
              cnt_d       = CW'(1);
              cd_d        = in_dly;
              head_time_d = {8'd0, in_dly};
            end else begin
              out_v_d = 1'b0;
              now_d   = sub_diff;
              dly_d   = in_dly;
              ntag_d  = in_tag;
              idx_d   = cnt_q;
              state_d = S_INS_RD;
            end
          end else if (cd_q != 24'd0) begin
            cd_d     = cd_q - 24'd1;
            pend_v_d = 1'b0;
            if (cd_q == 24'd1) begin
              state_d = S_EXP_RD;
            end
          end
        end
      end
      S_INS_RD: begin
        if (idx_q == '0) begin
          ram_we      = 1'b1;
          ram_waddr   = hd_q;
          ram_wdata   = {fire, ntag_q};
          head_time_d = fire;
          cnt_d       = cnt_q + CW'(1);
          if (dly_q < cd_q) begin
            cd_d = dly_q;
          end
          out_v_d = 1'b1;
          out_d   = '{kind: ostq_pkg::KIND_ACCEPT, fired_tag: 8'(ntag_q), last: 1'b1};
          state_d = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = wrap(hd_q, idx_q - CW'(1));
          state_d   = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        sub_a     = rd_ft;
        sub_b     = now_q;
        ram_we    = 1'b1;
        ram_waddr = wrap(hd_q, idx_q);
        if (sub_diff <= {8'd0, dly_q}) begin
          // Equal times keep arrival order: the new timer goes behind.
          ram_wdata = {fire, ntag_q};
          cnt_d     = cnt_q + CW'(1);
          if (dly_q < cd_q) begin
            cd_d = dly_q;
          end
          out_v_d = 1'b1;
          out_d   = '{kind: ostq_pkg::KIND_ACCEPT, fired_tag: 8'(ntag_q), last: 1'b1};
          state_d = S_IDLE;
        end else begin
          ram_wdata = ram_rdata;
          idx_d     = idx_q - CW'(1);
          state_d   = S_INS_RD;
        end
      end
      S_EXP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = hd_q;
        state_d   = S_EXP_DAT;
      end
      S_EXP_DAT: begin
        // The due time stays in head_time_q until the reload.
        sub_a = rd_ft;
        sub_b = head_time_q;
        if (!pend_v_q) begin
          pend_tag_d = rd_tag;
          pend_v_d   = 1'b1;
          hd_d       = wrap(hd_q, CW'(1));
          cnt_d      = cnt_q - CW'(1);
          state_d    = (cnt_q == CW'(1)) ? S_EXP_FIN : S_EXP_RD;
        end else if (out_free) begin
          out_v_d = 1'b1;
          if (rd_ft == head_time_q) begin
            out_d      = '{kind: ostq_pkg::KIND_FIRED, fired_tag: 8'(pend_tag_q),
                           last: 1'b0};
            pend_tag_d = rd_tag;
            hd_d       = wrap(hd_q, CW'(1));
            cnt_d      = cnt_q - CW'(1);
            state_d    = (cnt_q == CW'(1)) ? S_EXP_FIN : S_EXP_RD;
          end else begin
            out_d       = '{kind: ostq_pkg::KIND_FIRED, fired_tag: 8'(pend_tag_q),
                            last: 1'b1};
            head_time_d = rd_ft;
            cd_d        = sub_diff[23:0];
            state_d     = S_IDLE;
          end
        end
      end
      S_EXP_FIN: begin
        if (out_free) begin
          out_v_d = 1'b1;
          out_d   = '{kind: ostq_pkg::KIND_FIRED, fired_tag: 8'(pend_tag_q), last: 1'b1};
          cd_d    = 24'd0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      hd_q     <= '0;
      cd_q     <= 24'd0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      hd_q     <= hd_d;
      cd_q     <= cd_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_time_q <= head_time_d;
    idx_q       <= idx_d;
    now_q       <= now_d;
    dly_q       <= dly_d;
    ntag_q      <= ntag_d;
    pend_tag_q  <= pend_tag_d;
    out_q       <= out_d;
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(QUEUE_DEPTH))
  `ASSERT_IMPLY(a_idle_live_runs, clk_i, rst_ni, (state_q == S_IDLE) && (cnt_q != '0), cd_q != 24'd0)
  `ASSERT_IMPLY(a_idle_empty_stop, clk_i, rst_ni, (state_q == S_IDLE) && (cnt_q == '0), cd_q == 24'd0)
  `ASSERT_IMPLY(a_write_scope, clk_i, rst_ni, ram_we, (state_q == S_IDLE) || (state_q == S_INS_RD) || (state_q == S_INS_CMP))

endmodule
`default_nettype wire

### tb/one_shot_timer_event_queue_core_test.sv
// Self-checking testbench of the one-shot timer event queue core.
`timescale 1ns / 1ps
`default_nettype none
module one_shot_timer_event_queue_core_test;

  localparam int unsigned Depth      = 16;
  localparam int unsigned RandItems  = 140;
  localparam int unsigned StallLimit = 4000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  ostq_pkg::in_beat_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  ostq_pkg::out_beat_t out_data_o;

  one_shot_timer_event_queue_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Timer store as the block should hold it: sorted by fire time relative to
  // now, equal times in arrival order, entry 0 the head.
  logic [31:0] due_at [Depth];
  logic [7:0]  due_tag [Depth];
  int unsigned pending;
  logic [23:0] countdown_left;

  ostq_pkg::out_beat_t awaited_results[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          beat_taken = 1'b0;

  // Idling percentages of the current phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  function automatic ostq_pkg::out_beat_t make_result(logic [1:0] k, logic [7:0] t, logic l);
    ostq_pkg::out_beat_t r;
    r.kind = k;
    r.fired_tag = t;
    r.last = l;
    return r;
  endfunction

  // Applies one accepted input beat to the store and queues its results.
  task automatic apply_timer_beat(input ostq_pkg::in_beat_t b);
    logic [31:0] now_us, fire, rel, expired;
    logic [23:0] wait_us;
    int unsigned pos, first;
    wait_us = (b.delay_us == '0) ? 24'd1 : b.delay_us;
    if (b.opcode == ostq_pkg::OP_SCHED) begin
      if (pending >= Depth) begin
        awaited_results.push_back(make_result(ostq_pkg::KIND_FULL, b.tag, 1'b1));
      end else begin
        now_us = (pending == 0) ? 32'd0 : due_at[0] - {8'd0, countdown_left};
        fire = now_us + {8'd0, wait_us};
        rel = fire - now_us;
        pos = 0;
        while (pos < pending && (due_at[pos] - now_us) <= rel) pos++;
        for (int i = pending; i > pos; i--) begin
          due_at[i] = due_at[i-1];
          due_tag[i] = due_tag[i-1];
        end
        due_at[pos] = fire;
        due_tag[pos] = b.tag;
        if (pending == 0 || wait_us < countdown_left) countdown_left = wait_us;
        pending++;
        awaited_results.push_back(make_result(ostq_pkg::KIND_ACCEPT, b.tag, 1'b1));
      end
    end else if (countdown_left != '0) begin
      countdown_left = countdown_left - 24'd1;
      if (countdown_left == '0) begin
        expired = due_at[0];
        first = awaited_results.size();
        while (pending > 0 && due_at[0] == expired) begin
          awaited_results.push_back(make_result(ostq_pkg::KIND_FIRED, due_tag[0], 1'b0));
          for (int i = 1; i < pending; i++) begin
            due_at[i-1] = due_at[i];
            due_tag[i-1] = due_tag[i];
          end
          pending--;
        end
        if (awaited_results.size() > first)
          awaited_results[awaited_results.size()-1].last = 1'b1;
        countdown_left = (pending > 0) ? 24'(due_at[0] - expired) : 24'd0;
      end
    end
  endtask

  task automatic note_mismatch(input ostq_pkg::out_beat_t want,
                               input ostq_pkg::out_beat_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch: expected kind %0d tag %02h last %0d, got kind %0d tag %02h last %0d",
               want.kind, want.fired_tag, want.last, got.kind, got.fired_tag, got.last);
  endtask

  // Both sides are sampled here, before the block's own updates of this edge land.
  always @(posedge clk_i) begin
    ostq_pkg::out_beat_t want;
    beat_taken = in_valid_i && in_ready_o;
    if (beat_taken) apply_timer_beat(in_data_i);
    if (out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        want = '0;
        note_mismatch(want, out_data_o);
      end else begin
        want = awaited_results.pop_front();
        if (want !== out_data_o) note_mismatch(want, out_data_o);
      end
    end
    if (rst_ni && !beat_taken && !(out_valid_o && out_ready_i)) quiet_cycles++;
    else quiet_cycles = 0;
    if (quiet_cycles >= StallLimit) begin
      $display("one_shot_timer_event_queue_core regression: fail");
      $finish;
    end
  end

  // The receiver stalls at random, by the percentage of the current phase.
  always @(negedge clk_i)
    out_ready_i = ($urandom_range(99) >= recv_stall_pct);

  // Drives one beat at the falling edge and holds it until it is taken.
  task automatic send_beat(input ostq_pkg::in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = b;
    do @(negedge clk_i); while (!beat_taken);
    in_valid_i = 1'b0;
  endtask

  function automatic ostq_pkg::in_beat_t timer_beat(logic op, logic [23:0] d, logic [7:0] t);
    ostq_pkg::in_beat_t b;
    b.opcode = op;
    b.delay_us = d;
    b.tag = t;
    return b;
  endfunction

  typedef struct {
    ostq_pkg::in_beat_t  beat;
    bit                  typed;
    ostq_pkg::out_beat_t want;
  } stim_row_t;

  stim_row_t directed[$];

  task automatic add_row(ostq_pkg::in_beat_t b, bit typed = 1'b0,
                         ostq_pkg::out_beat_t w = '0);
    stim_row_t r;
    r.beat = b;
    r.typed = typed;
    r.want = w;
    directed.push_back(r);
  endtask

  initial begin
    ostq_pkg::in_beat_t b;
    int unsigned first;
    pending = 0;
    countdown_left = '0;

    // Directed rows. A tick while stopped gives nothing; a zero delay counts as one.
    add_row(timer_beat(ostq_pkg::OP_TICK, 24'd0, 8'd0));
    add_row(timer_beat(ostq_pkg::OP_SCHED, 24'd0, 8'h00), 1'b1,
            make_result(ostq_pkg::KIND_ACCEPT, 8'h00, 1'b1));
    add_row(timer_beat(ostq_pkg::OP_TICK, 24'd0, 8'd0), 1'b1,
            make_result(ostq_pkg::KIND_FIRED, 8'h00, 1'b1));
    // Two timers due together, then a shorter one that cuts the countdown.
    add_row(timer_beat(ostq_pkg::OP_SCHED, 24'd3, 8'hA1));
    add_row(timer_beat(ostq_pkg::OP_SCHED, 24'd3, 8'hA2));
    add_row(timer_beat(ostq_pkg::OP_SCHED, 24'd1, 8'hFF), 1'b1,
            make_result(ostq_pkg::KIND_ACCEPT, 8'hFF, 1'b1));
    add_row(timer_beat(ostq_pkg::OP_TICK, 24'd0, 8'd0));
    add_row(timer_beat(ostq_pkg::OP_TICK, 24'd0, 8'd0));
    add_row(timer_beat(ostq_pkg::OP_TICK, 24'd0, 8'd0));
    // The longest delay stays pending; fifteen more fill the store, then one is dropped.
    add_row(timer_beat(ostq_pkg::OP_SCHED, 24'hFFFFFF, 8'h5A));
    for (int i = 0; i < 15; i++)
      add_row(timer_beat(ostq_pkg::OP_SCHED, 24'd2, 8'(8'h10 + i)));
    add_row(timer_beat(ostq_pkg::OP_SCHED, 24'd7, 8'hC3), 1'b1,
            make_result(ostq_pkg::KIND_FULL, 8'hC3, 1'b1));
    add_row(timer_beat(ostq_pkg::OP_TICK, 24'd0, 8'd0));
    add_row(timer_beat(ostq_pkg::OP_TICK, 24'd0, 8'd0));

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      // A typed row starts with nothing outstanding, so its results are the only new ones.
      if (directed[i].typed)
        while (awaited_results.size() != 0) @(negedge clk_i);
      first = awaited_results.size();
      send_beat(directed[i].beat);
      // Typed rows also guard the predictor against a slip of its own.
      if (directed[i].typed && (awaited_results.size() <= first
          || awaited_results[awaited_results.size()-1] !== directed[i].want))
        note_mismatch(directed[i].want,
                      awaited_results.size() > first ?
                      awaited_results[awaited_results.size()-1] : '0);
    end

    // Random phases: no idling, sender idle, receiver stalling, both lightly.
    for (int phase = 0; phase < 4; phase++) begin
      // Hold the sender back until every result so far has come.
      while (awaited_results.size() != 0) @(negedge clk_i);
      send_idle_pct  = (phase == 1) ? 72 : (phase == 3) ? 7 : 0;
      recv_stall_pct = (phase == 2) ? 72 : (phase == 3) ? 7 : 0;
      for (int n = 0; n < RandItems / 4; n++) begin
        if ($urandom_range(99) < 55) begin
          b = timer_beat(ostq_pkg::OP_TICK, 24'($urandom), 8'($urandom));
        end else begin
          b = timer_beat(ostq_pkg::OP_SCHED, 24'($urandom_range(12)), 8'($urandom));
          // Now and then a long timer, which stays pending for the rest of the run.
          if ($urandom_range(49) == 0) b.delay_us = 24'($urandom);
        end
        send_beat(b);
      end
    end

    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("one_shot_timer_event_queue_core regression: pass");
    end else begin
      $display("one_shot_timer_event_queue_core regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
+incdir+design
design/ostq_pkg.sv
design/ostq_ram.sv
design/ostq_sub.sv
design/one_shot_timer_event_queue_core.sv
tb/one_shot_timer_event_queue_core_test.sv
